### rtl/hvcs_pkg.sv
// ----------------------------------------------------------------------------
// hvcs_pkg
// Types, constants and helper functions shared by the calibration step core.
// ----------------------------------------------------------------------------
`default_nettype none

package hvcs_pkg;

	localparam int STATIONS  = 32;
	localparam int DETECTORS = 20;
	localparam int ENTRIES   = STATIONS * DETECTORS;
	localparam int AW        = $clog2(ENTRIES);

	localparam int VW = 12;
	localparam int CW = 20;
	localparam int NW = 46;
	localparam int RW = 44;

	localparam logic [VW-1:0] VMAX     = 12'd3800;
	localparam logic [VW-1:0] VSTEP    = 12'd300;
	localparam logic [CW:0]   TOL_POS  = 21'sd50;
	localparam logic [CW:0]   TOL_NEG  = -21'sd50;
	localparam logic [CW-1:0] AMP_MIN  = 20'd20;

	localparam logic [1:0] CFG_TARGET  = 2'd0;
	localparam logic [1:0] CFG_NOMINAL = 2'd1;
	localparam logic [1:0] CFG_MAXATT  = 2'd2;
	localparam logic [1:0] CFG_SLOPE   = 2'd3;

	localparam logic REQ_PRESET = 1'b1;

	typedef struct packed {
		logic [VW-1:0] volt;
		logic [VW-1:0] saved;
		logic          active;
		logic [7:0]    att;
	} entry_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] det;
	} succ_t;

	typedef enum logic [1:0] {
		P_WR,
		P_SUCC,
		P_LIN
	} path_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_CAP,
		S_DEC,
		S_MUL,
		S_NUM,
		S_DCHK,
		S_DIV,
		S_SRD,
		S_SCAP,
		S_WR,
		S_WS,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic latch_in;
		logic rd_idx;
		logic rd_succ;
		logic cap_ent;
		logic decide;
		logic mul;
		logic num;
		logic divchk;
		logic div;
		logic cap_succ;
		logic wr_idx;
		logic wr_succ;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic  clr_last;
		logic  bad_addr;
		path_t path;
		logic  div_go;
		logic  div_last;
		logic  has_succ;
	} stat_t;

	function automatic logic [VW-1:0] sat_v(input logic [VW:0] v);
		logic [VW-1:0] r;
		begin
			r = (v > {1'b0, VMAX}) ? VMAX : v[VW-1:0];
			return r;
		end
	endfunction

	function automatic succ_t succ_of(input logic [4:0] d);
		succ_t s;
		begin
			s.valid = 1'b1;
			s.det   = 5'd0;
			if (d < 5'd5 || (d > 5'd5 && d < 5'd11)) begin
				s.det = d + 5'd1;
			end else if (d == 5'd5) begin
				s.det = 5'd12;
			end else if (d == 5'd11) begin
				s.det = 5'd13;
			end else if (d >= 5'd12 && d <= 5'd17) begin
				s.det = d + 5'd2;
			end else begin
				s.valid = 1'b0;
			end
			return s;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/hvcs_ram.sv
// ----------------------------------------------------------------------------
// hvcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/hvcs_datapath.sv
// ----------------------------------------------------------------------------
// hvcs_datapath
// Configuration registers, detector table, correction arithmetic and result.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcs_datapath import hvcs_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	output stat_t              stat,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_idx,
	input  wire logic [31:0]   cfg_data,
	input  wire logic          req_type,
	input  wire logic [4:0]    station,
	input  wire logic [4:0]    detector,
	input  wire logic [CW-1:0] group_count,
	input  wire logic [CW-1:0] own_count,
	input  wire logic [CW-1:0] own_amp_count,
	input  wire logic [VW-1:0] load_voltage,
	input  wire logic          load_active,
	output logic               finished,
	output logic [VW-1:0]      voltage,
	output logic [VW-1:0]      saved_voltage,
	output logic               next_valid,
	output logic [4:0]         next_detector,
	output logic [7:0]         attempt_count
);

	logic [CW-1:0] target_q;
	logic [VW-1:0] nominal_q;
	logic [7:0]    maxatt_q;
	logic [31:0]   slope_q;

	logic          req_q;
	logic [4:0]    station_q;
	logic [4:0]    det_q;
	logic [CW-1:0] grp_q;
	logic [CW-1:0] own_q;
	logic [CW-1:0] amp_q;
	logic [VW-1:0] lv_q;
	logic          la_q;

	logic [AW-1:0] clr_q;
	entry_t        ent_q;
	entry_t        newe_q;
	entry_t        sent_q;
	logic          fin_q;
	succ_t         succ_q;
	logic [RW-1:0] prod_q;
	logic [NW-1:0] num_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [VW-1:0] quo_q;
	logic [3:0]    cnt_q;

	logic [AW-1:0] idx;
	logic [AW-1:0] sidx;
	succ_t         succ;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic          we;
	entry_t        rdata;
	logic [7:0]    att_new;
	logic [CW:0]   diff;
	logic          in_tol;
	logic          limit;
	logic          lin;
	logic          fin_now;
	path_t         path;
	entry_t        newe_d;
	entry_t        sent_d;
	logic [31:0]   slope_eff;
	logic          num_pos;
	logic          num_big;
	logic          ge;
	logic [VW-1:0] quo_nx;
	logic [CW:0]   tdiff;

	assign idx  = AW'(station_q * DETECTORS) + AW'(det_q);
	assign succ = succ_of(det_q);
	assign sidx = AW'(station_q * DETECTORS) + AW'(succ_q.det);

	assign raddr = cmd.rd_succ ? sidx : idx;
	assign we    = cmd.clr | cmd.wr_idx | cmd.wr_succ;
	assign waddr = cmd.clr ? clr_q : (cmd.wr_succ ? sidx : idx);
	assign wdata = cmd.clr ? entry_t'('0) : (cmd.wr_succ ? sent_q : newe_q);

	hvcs_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign att_new   = (ent_q.att == 8'hFF) ? 8'hFF : ent_q.att + 8'd1;
	assign diff      = {1'b0, grp_q} - {1'b0, target_q};
	assign in_tol    = ($signed(diff) <= $signed(TOL_POS)) &&
		($signed(diff) >= $signed(TOL_NEG));
	assign limit     = att_new >= maxatt_q;
	assign lin       = ($signed(diff) > $signed(TOL_POS)) && (amp_q > AMP_MIN);
	assign fin_now   = (req_q != REQ_PRESET) && ent_q.active && (in_tol || limit);
	assign slope_eff = (slope_q == 32'd0) ? 32'd1 : slope_q;
	assign tdiff     = {1'b0, target_q} - {1'b0, own_q};
	assign num_pos   = !num_q[NW-1] && (num_q != '0);
	assign num_big   = num_q[NW-2:0] >= {1'b0, slope_eff, 12'd0};
	assign ge        = rem_q >= dvs_q;
	assign quo_nx    = {quo_q[VW-2:0], ge};

	always_comb begin
		path = P_WR;
		if (req_q != REQ_PRESET && ent_q.active) begin
			if (in_tol || limit) begin
				path = succ.valid ? P_SUCC : P_WR;
			end else if (lin) begin
				path = P_LIN;
			end
		end
	end

	always_comb begin
		newe_d     = ent_q;
		newe_d.att = att_new;
		if (req_q == REQ_PRESET) begin
			newe_d.volt   = sat_v({1'b0, lv_q});
			newe_d.active = la_q;
			newe_d.att    = 8'd0;
		end else if (ent_q.active) begin
			if (in_tol || limit) begin
				newe_d.volt   = '0;
				newe_d.saved  = limit ? '0 : ent_q.volt;
				newe_d.active = 1'b0;
			end else if (!lin) begin
				newe_d.volt = sat_v({1'b0, ent_q.volt} + {1'b0, VSTEP});
			end
		end
	end

	always_comb begin
		sent_d        = rdata;
		sent_d.active = 1'b1;
		sent_d.volt   = sat_v({1'b0, nominal_q});
	end

	assign stat.clr_last = clr_q == AW'(ENTRIES - 1);
	assign stat.bad_addr = ({1'b0, station_q} >= 6'(STATIONS)) || (det_q >= 5'(DETECTORS));
	assign stat.path     = path;
	assign stat.div_go   = num_pos && !num_big;
	assign stat.div_last = cnt_q == 4'd0;
	assign stat.has_succ = succ_q.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= 20'd1000;
			nominal_q <= 12'd3000;
			maxatt_q  <= 8'd10;
			slope_q   <= 32'd65536;
			clr_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TARGET: begin
						target_q <= cfg_data[CW-1:0];
					end
					CFG_NOMINAL: begin
						nominal_q <= cfg_data[VW-1:0];
					end
					CFG_MAXATT: begin
						maxatt_q <= cfg_data[7:0];
					end
					CFG_SLOPE: begin
						slope_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			req_q     <= req_type;
			station_q <= station;
			det_q     <= detector;
			grp_q     <= group_count;
			own_q     <= own_count;
			amp_q     <= own_amp_count;
			lv_q      <= load_voltage;
			la_q      <= load_active;
		end
		if (cmd.cap_ent) begin
			ent_q <= rdata;
		end
		if (cmd.decide) begin
			fin_q  <= fin_now;
			succ_q <= fin_now ? succ : succ_t'('0);
			newe_q <= newe_d;
		end
		if (cmd.mul) begin
			prod_q <= slope_eff * ent_q.volt;
		end
		if (cmd.num) begin
			num_q <= $signed({2'b0, prod_q}) + $signed({{9{tdiff[CW]}}, tdiff, 16'd0});
		end
		if (cmd.divchk) begin
			rem_q <= num_q[RW-1:0];
			dvs_q <= {1'b0, slope_eff, 11'd0};
			quo_q <= '0;
			cnt_q <= 4'(VW - 1);
			if (!num_pos) begin
				newe_q.volt <= '0;
			end else if (num_big) begin
				newe_q.volt <= VMAX;
			end
		end
		if (cmd.div) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= quo_nx;
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd0) begin
				newe_q.volt <= sat_v({1'b0, quo_nx});
			end
		end
		if (cmd.cap_succ) begin
			sent_q <= sent_d;
		end
		if (cmd.load_out) begin
			if (stat.bad_addr) begin
				finished      <= 1'b0;
				voltage       <= '0;
				saved_voltage <= '0;
				next_valid    <= 1'b0;
				next_detector <= '0;
				attempt_count <= '0;
			end else begin
				finished      <= fin_q;
				voltage       <= newe_q.volt;
				saved_voltage <= newe_q.saved;
				next_valid    <= succ_q.valid;
				next_detector <= succ_q.valid ? succ_q.det : 5'd0;
				attempt_count <= newe_q.att;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/hvcs_ctrl.sv
// ----------------------------------------------------------------------------
// hvcs_ctrl
// Sequencer for table clearing, item processing and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcs_ctrl import hvcs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  wire logic  out_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_nx     = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_idx = 1'b1;
				state_nx   = stat.bad_addr ? S_OUT : S_CAP;
			end
			S_CAP: begin
				cmd.cap_ent = 1'b1;
				state_nx    = S_DEC;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				case (stat.path)
					P_SUCC: begin
						state_nx = S_SRD;
					end
					P_LIN: begin
						state_nx = S_MUL;
					end
					default: begin
						state_nx = S_WR;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_NUM;
			end
			S_NUM: begin
				cmd.num  = 1'b1;
				state_nx = S_DCHK;
			end
			S_DCHK: begin
				cmd.divchk = 1'b1;
				state_nx   = stat.div_go ? S_DIV : S_WR;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_last) begin
					state_nx = S_WR;
				end
			end
			S_SRD: begin
				cmd.rd_succ = 1'b1;
				state_nx    = S_SCAP;
			end
			S_SCAP: begin
				cmd.cap_succ = 1'b1;
				state_nx     = S_WR;
			end
			S_WR: begin
				cmd.wr_idx = 1'b1;
				state_nx   = stat.has_succ ? S_WS : S_OUT;
			end
			S_WS: begin
				cmd.wr_succ = 1'b1;
				state_nx    = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/detector_hv_calibration_step_core.sv
// ----------------------------------------------------------------------------
// detector_hv_calibration_step_core
// One calibration step of a per-station detector high-voltage table.
// ----------------------------------------------------------------------------
// After reset the detector table is cleared in a pass over its 640 entries, one
// entry per cycle, during which no item is taken; configuration writes are taken
// at all times. Items are then handled one at a time, each giving one result. An
// address out of range goes from the table read straight to the result. Other
// items read and capture their entry, decide and write it back; a finish that
// enables a successor also reads and writes the successor entry, and a linear
// correction first multiplies, forms the numerator and may run the 12-step
// restoring divider by the slope. The result sits in an output register, so the
// next item is taken while it waits.
`default_nettype none

module detector_hv_calibration_step_core import hvcs_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_idx,
	input  wire logic [31:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          req_type,
	input  wire logic [4:0]    station,
	input  wire logic [4:0]    detector,
	input  wire logic [CW-1:0] group_count,
	input  wire logic [CW-1:0] own_count,
	input  wire logic [CW-1:0] own_amp_count,
	input  wire logic [VW-1:0] load_voltage,
	input  wire logic          load_active,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               finished,
	output logic [VW-1:0]      voltage,
	output logic [VW-1:0]      saved_voltage,
	output logic               next_valid,
	output logic [4:0]         next_detector,
	output logic [7:0]         attempt_count
);

	cmd_t  cmd;
	stat_t stat;

	hvcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	hvcs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.station       (station),
		.detector      (detector),
		.group_count   (group_count),
		.own_count     (own_count),
		.own_amp_count (own_amp_count),
		.load_voltage  (load_voltage),
		.load_active   (load_active),
		.finished      (finished),
		.voltage       (voltage),
		.saved_voltage (saved_voltage),
		.next_valid    (next_valid),
		.next_detector (next_detector),
		.attempt_count (attempt_count)
	);

endmodule

`default_nettype wire

### rtl/hvcs_checker.sv
// ----------------------------------------------------------------------------
// hvcs_checker
// Port-level checks of the calibration step core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcs_checker import hvcs_pkg::*; (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire logic          finished,
	input wire logic [VW-1:0] voltage,
	input wire logic [VW-1:0] saved_voltage,
	input wire logic          next_valid
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(voltage) && $stable(finished))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while the previous one is in work");

	a_next_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && next_valid |-> finished)
		else $error("successor enabled without finish");

	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> voltage == '0)
		else $error("finished detector kept a voltage");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> voltage <= VMAX && saved_voltage <= VMAX)
		else $error("voltage out of range");

endmodule

bind detector_hv_calibration_step_core hvcs_checker u_hvcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.finished      (finished),
	.voltage       (voltage),
	.saved_voltage (saved_voltage),
	.next_valid    (next_valid)
);

`default_nettype wire
